/* rtl/core/bch_pkg.sv */
// Shared types and constants for the barometric compensation and health block.
// No dependencies; imported by bch_health, baro_compensation_health_top and the testbench.
package bch_pkg;

  // Field widths
  localparam int RAW_W  = 24;
  localparam int COEF_W = 16;
  localparam int TEMP_W = 15;
  localparam int PRES_W = 17;
  localparam int IDX_W  = 3;
  localparam int NUM_COEF = 6;

  // Datapath widths
  localparam int DT_W   = 25;   // D2 - C5*256
  localparam int MUL_W  = 26;   // shared multiplier operand
  localparam int PROD_W = 52;   // shared multiplier product
  localparam int ACC_W  = 48;   // OFF, SENS and their corrections
  localparam int SUM_W  = 64;   // D1 * SENS
  localparam int TMP_W  = 20;   // internal temperature
  localparam int T2_W   = 18;   // dT^2 >> 31

  // Calibration register indexes
  localparam logic [IDX_W-1:0] REG_SENS    = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFF     = 3'd1;
  localparam logic [IDX_W-1:0] REG_SENS_TC = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFF_TC  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TREF    = 3'd4;
  localparam logic [IDX_W-1:0] REG_TSLOPE  = 3'd5;

  // Health counter limits
  localparam logic [3:0] STUCK_LIMIT   = 4'd10;
  localparam logic [5:0] RECOVER_LIMIT = 6'd50;
  localparam logic [3:0] CLEAN_LIMIT   = 4'd10;
  localparam logic [2:0] FAULT_LIMIT   = 3'd5;

  // Update request from the sequencer to the health monitor
  typedef struct packed {
    logic              upd;
    logic              fault;
    logic [PRES_W-1:0] pres;
  } health_req_t;

  // Health flags after the current item
  typedef struct packed {
    logic stuck;
    logic connected;
    logic error;
    logic reinit;
  } health_t;

endpackage

/* rtl/core/bch_health.sv */
// Sensor health monitor: stuck-pressure detector, clean and fault run counters.
// Depends on bch_pkg. Flags show the state after the item being committed.
module bch_health (
  input  logic                 clk,
  input  logic                 rst,
  input  bch_pkg::health_req_t req,
  output bch_pkg::health_t     flags
);
  import bch_pkg::*;

  logic [PRES_W-1:0] last_pressure, last_pressure_next;
  logic [3:0]        stuck_count, stuck_count_next;
  logic [5:0]        change_count, change_count_next;
  logic              stuck_flag, stuck_flag_next;
  logic [3:0]        clean_count, clean_count_next;
  logic [2:0]        fault_count, fault_count_next;
  logic              connected_flag, connected_flag_next;
  logic              error_flag, error_flag_next;

  // Next state for the item on req
  always_comb begin
    last_pressure_next  = last_pressure;
    stuck_count_next    = stuck_count;
    change_count_next   = change_count;
    stuck_flag_next     = stuck_flag;
    clean_count_next    = clean_count;
    fault_count_next    = fault_count;
    connected_flag_next = connected_flag;
    error_flag_next     = error_flag;
    if (req.fault) begin
      clean_count_next    = '0;
      if (fault_count < FAULT_LIMIT) fault_count_next = fault_count + 3'd1;
      connected_flag_next = 1'b0;
      error_flag_next     = 1'b1;
    end else begin
      if (last_pressure == req.pres) begin
        if (change_count > 6'd1) change_count_next = change_count - 6'd1;
        if (stuck_count < STUCK_LIMIT) stuck_count_next = stuck_count + 4'd1;
      end else begin
        if (stuck_count > 4'd1) stuck_count_next = stuck_count - 4'd1;
        last_pressure_next = req.pres;
        if (change_count < RECOVER_LIMIT) change_count_next = change_count + 6'd1;
      end
      if (stuck_count_next == STUCK_LIMIT) begin
        stuck_flag_next = 1'b1;
        error_flag_next = 1'b1;
      end else if (change_count_next == RECOVER_LIMIT) begin
        stuck_flag_next = 1'b0;
      end
      if (clean_count < CLEAN_LIMIT) clean_count_next = clean_count + 4'd1;
      fault_count_next = '0;
    end
    // recovery once a clean run completes
    if (clean_count_next == CLEAN_LIMIT && !stuck_flag_next) begin
      connected_flag_next = 1'b1;
      error_flag_next     = 1'b0;
    end
  end

  assign flags.stuck     = stuck_flag_next;
  assign flags.connected = connected_flag_next;
  assign flags.error     = error_flag_next;
  assign flags.reinit    = (fault_count_next == FAULT_LIMIT);

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressure  <= '0;
      stuck_count    <= '0;
      change_count   <= '0;
      stuck_flag     <= 1'b0;
      clean_count    <= '0;
      fault_count    <= '0;
      connected_flag <= 1'b0;
      error_flag     <= 1'b0;
    end else if (req.upd) begin
      last_pressure  <= last_pressure_next;
      stuck_count    <= stuck_count_next;
      change_count   <= change_count_next;
      stuck_flag     <= stuck_flag_next;
      clean_count    <= clean_count_next;
      fault_count    <= fault_count_next;
      connected_flag <= connected_flag_next;
      error_flag     <= error_flag_next;
    end
  end

endmodule

/* rtl/core/baro_compensation_health_top.sv */
// Barometric sensor second-order temperature compensation with health flags.
// A clean item steps the sequencer through every state up to ST_FIN; a faulty one jumps straight
// from ST_IDLE to ST_FIN. A clean item makes eight passes through the one shared 26x26
// multiplier plus the add and clamp steps; no new beat while busy, and a stalled
// output holds the sequencer in its last step.
// Reset (rst, synchronous): calibration words and all health state clear to zero.
// Depends on bch_pkg and bch_health.
module baro_compensation_health_top (
  input  logic                       clk,
  input  logic                       rst,
  // input stream: [23:0] raw_pressure, [47:24] raw_temperature
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [47:0]                s_tdata,
  // output stream: [14:0] temperature, [31:15] pressure, [32] sample_valid,
  // [33] data_error, [34] sensor_connected, [35] sensor_error, [36] reinit_request
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [39:0]                m_tdata,
  // calibration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bch_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bch_pkg::COEF_W-1:0] cfg_data
);
  import bch_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DT, ST_MT, ST_MOFF, ST_MSENS, ST_MT2, ST_MA, ST_MB,
    ST_SEC1, ST_SEC2, ST_MPL, ST_MPH, ST_PSUM, ST_PDIFF, ST_FIN
  } state_t;

  typedef struct packed {
    logic                     reinit;
    logic                     error;
    logic                     connected;
    logic                     data_error;
    logic                     sample_valid;
    logic [PRES_W-1:0]        pressure;
    logic signed [TEMP_W-1:0] temperature;
  } out_t;

  localparam logic signed [TMP_W-1:0] T_REF  = 20'sd2000;
  localparam logic signed [TMP_W-1:0] T_COLD = -20'sd1500;
  localparam logic signed [TMP_W-1:0] T_MIN  = -20'sd4000;
  localparam logic signed [TMP_W-1:0] T_MAX  = 20'sd8500;
  localparam logic signed [ACC_W-1:0] P_MIN  = 48'sd1000;
  localparam logic signed [ACC_W-1:0] P_MAX  = 48'sd120000;

  state_t                   state;
  logic [COEF_W-1:0]        coeff [NUM_COEF];
  logic [RAW_W-1:0]         d1, d2;
  logic                     fault;
  logic signed [DT_W-1:0]   dt;
  logic signed [TMP_W-1:0]  temp;
  logic [T2_W-1:0]          t2;
  logic signed [ACC_W-1:0]  off, sens, a_sq, off2, sens2, pdiff;
  logic signed [PROD_W-1:0] prod, plo;
  logic signed [SUM_W-1:0]  psum;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  out_t                     out_q;
  logic                     out_q_valid;

  logic                     in_fault, coef_zero, low, cold;
  logic signed [ACC_W-1:0]  b_sq, a5, p_full;
  logic signed [TMP_W-1:0]  temp_sat;
  logic [PRES_W-1:0]        pres_sat;
  health_req_t              hreq;
  health_t                  hflags;
  logic                     out_free;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_q_valid;
  assign m_tdata   = {3'b000, out_q};
  assign out_free  = !out_q_valid || m_tready;

  // Read fault check on the incoming beat and the calibration words
  always_comb begin
    coef_zero = 1'b0;
    for (int i = 0; i < NUM_COEF; i++) begin
      if (coeff[i] == '0) coef_zero = 1'b1;
    end
    in_fault = coef_zero
            || s_tdata[RAW_W-1:0] == '0 || s_tdata[RAW_W-1:0] == '1
            || s_tdata[2*RAW_W-1:RAW_W] == '0 || s_tdata[2*RAW_W-1:RAW_W] == '1;
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MT: begin
        mul_a = MUL_W'(dt);
        mul_b = signed'(MUL_W'(coeff[REG_TSLOPE]));
      end
      ST_MOFF: begin
        mul_a = signed'(MUL_W'(coeff[REG_OFF_TC]));
        mul_b = MUL_W'(dt);
      end
      ST_MSENS: begin
        mul_a = signed'(MUL_W'(coeff[REG_SENS_TC]));
        mul_b = MUL_W'(dt);
      end
      ST_MT2: begin
        mul_a = MUL_W'(dt);
        mul_b = MUL_W'(dt);
      end
      ST_MA: begin
        mul_a = MUL_W'(temp - T_REF);
        mul_b = MUL_W'(temp - T_REF);
      end
      ST_MB: begin
        mul_a = MUL_W'(temp - T_COLD);
        mul_b = MUL_W'(temp - T_COLD);
      end
      ST_MPL: begin
        mul_a = signed'(MUL_W'(d1));
        mul_b = signed'(MUL_W'(sens[19:0]));
      end
      ST_MPH: begin
        mul_a = signed'(MUL_W'(d1));
        mul_b = MUL_W'(sens >>> 20);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Second-order terms and output saturation
  always_comb begin
    low    = (temp < T_REF);
    cold   = (temp < T_COLD);
    b_sq   = ACC_W'(prod);
    a5     = a_sq + (a_sq <<< 2);
    p_full = pdiff >>> 15;
    if (temp < T_MIN)      temp_sat = T_MIN;
    else if (temp > T_MAX) temp_sat = T_MAX;
    else                   temp_sat = temp;
    if (p_full < P_MIN)      pres_sat = PRES_W'(P_MIN);
    else if (p_full > P_MAX) pres_sat = PRES_W'(P_MAX);
    else                     pres_sat = PRES_W'(p_full);
  end

  assign hreq.upd   = (state == ST_FIN) && out_free;
  assign hreq.fault = fault;
  assign hreq.pres  = fault ? '0 : pres_sat;

  bch_health u_health (
    .clk   (clk),
    .rst   (rst),
    .req   (hreq),
    .flags (hflags)
  );

  // Calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEF; i++) coeff[i] <= '0;
    end else if (cfg_valid) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        if (cfg_index == IDX_W'(i)) coeff[i] <= cfg_data;
      end
    end
  end

  // Shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a * mul_b);
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_q_valid <= 1'b0;
    end else begin
      // output beat loads on the last step, drains on m_tready
      if (state == ST_FIN && out_free) out_q_valid <= 1'b1;
      else if (m_tready)               out_q_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            d1    <= s_tdata[RAW_W-1:0];
            d2    <= s_tdata[2*RAW_W-1:RAW_W];
            fault <= in_fault;
            state <= in_fault ? ST_FIN : ST_DT;
          end
        end
        ST_DT: begin
          dt    <= signed'({1'b0, d2}) - signed'({1'b0, coeff[REG_TREF], 8'h00});
          state <= ST_MT;
        end
        ST_MT:    state <= ST_MOFF;
        ST_MOFF: begin
          temp  <= TMP_W'(prod >>> 23) + T_REF;
          state <= ST_MSENS;
        end
        ST_MSENS: begin
          off   <= ACC_W'(prod >>> 7) + signed'(ACC_W'({coeff[REG_OFF], 16'h0000}));
          state <= ST_MT2;
        end
        ST_MT2: begin
          sens  <= ACC_W'(prod >>> 8) + signed'(ACC_W'({coeff[REG_SENS], 15'h0000}));
          state <= ST_MA;
        end
        ST_MA: begin
          t2    <= prod[48:31];
          state <= ST_MB;
        end
        ST_MB: begin
          a_sq  <= ACC_W'(prod);
          state <= ST_SEC1;
        end
        ST_SEC1: begin
          // prod holds (TEMP+1500)^2 here
          if (!low) begin
            off2  <= '0;
            sens2 <= '0;
          end else if (cold) begin
            off2  <= (a5 >>> 1) + ((b_sq <<< 3) - b_sq);
            sens2 <= (a5 >>> 2) + (((b_sq <<< 3) + (b_sq <<< 1) + b_sq) >>> 1);
          end else begin
            off2  <= a5 >>> 1;
            sens2 <= a5 >>> 2;
          end
          state <= ST_SEC2;
        end
        ST_SEC2: begin
          if (low) temp <= temp - signed'(TMP_W'(t2));
          off   <= off - off2;
          sens  <= sens - sens2;
          state <= ST_MPL;
        end
        ST_MPL:   state <= ST_MPH;
        ST_MPH: begin
          plo   <= prod;
          state <= ST_PSUM;
        end
        ST_PSUM: begin
          psum  <= (SUM_W'(prod) <<< 20) + SUM_W'(plo);
          state <= ST_PDIFF;
        end
        ST_PDIFF: begin
          pdiff <= ACC_W'(psum >>> 21) - off;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_q.temperature  <= fault ? '0 : TEMP_W'(temp_sat);
            out_q.pressure     <= fault ? '0 : pres_sat;
            out_q.sample_valid <= !fault;
            out_q.data_error   <= hflags.stuck;
            out_q.connected    <= hflags.connected;
            out_q.error        <= hflags.error;
            out_q.reinit       <= hflags.reinit;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A faulty item reports zero temperature and pressure
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_q.sample_valid |-> out_q.pressure == '0 && out_q.temperature == '0)
    else $error("faulty item with non-zero readings");

  // A clean item reports a saturated pressure
  a_pres_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_q.sample_valid |->
      out_q.pressure >= PRES_W'(1000) && out_q.pressure <= PRES_W'(120000))
    else $error("pressure outside saturation range");

  // Re-init request only follows a faulty item
  a_reinit_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_q.reinit |-> !out_q.sample_valid)
    else $error("re-init request on a clean item");

  // A faulty item always drops the connected flag
  a_conn_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_q.connected |-> out_q.sample_valid)
    else $error("connected reported on a faulty item");

  // An accepted beat starts the sequencer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sequencer did not leave idle");

endmodule

/* sim/tb_baro_compensation_health_top.sv */
// Testbench for baro_compensation_health_top: directed table then random readings,
// each output beat checked against an in-bench compensation and health predictor.
// Depends on bch_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_baro_compensation_health_top;
  import bch_pkg::*;

  // fields from the top bit down, so temperature lands in the low bits
  typedef struct packed {
    logic               reinit_request;
    logic               sensor_error;
    logic               sensor_connected;
    logic               data_error;
    logic               sample_valid;
    logic [16:0]        pressure;
    logic signed [14:0] temperature;
  } baro_out_t;

  typedef struct {
    logic [23:0] d1;
    logic [23:0] d2;
    logic        fixed;   // expected result typed in below
    baro_out_t   res;
  } stim_row_t;

  localparam int RAND_ITEMS = 600;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  baro_compensation_health_top dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state
  logic [15:0] cal [NUM_COEF];
  logic [16:0] prev_pres;
  int unsigned stuck_cnt, change_cnt, clean_cnt, fault_cnt;
  bit stuck_f, conn_f, err_f;

  baro_out_t expected_q [$];
  int errors = 0;
  int cycles = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic longint fsh(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic baro_out_t compensate(input logic [23:0] d1, input logic [23:0] d2);
    baro_out_t r;
    bit flt;
    longint dt, tmp, off, sens, t2, a, b, off2, sens2, p;
    r = '0;
    flt = (d1 == 0) || (d1 == 24'hFFFFFF) || (d2 == 0) || (d2 == 24'hFFFFFF);
    for (int i = 0; i < NUM_COEF; i++) if (cal[i] == 0) flt = 1;
    if (!flt) begin
      dt = longint'(d2) - longint'(cal[REG_TREF]) * 256;
      tmp = 2000 + fsh(dt * longint'(cal[REG_TSLOPE]), 23);
      off = longint'(cal[REG_OFF]) * 65536 + fsh(longint'(cal[REG_OFF_TC]) * dt, 7);
      sens = longint'(cal[REG_SENS]) * 32768 + fsh(longint'(cal[REG_SENS_TC]) * dt, 8);
      if (tmp < 2000) begin
        t2 = longint'(longint'(unsigned'(dt * dt)) >> 31);
        a = (tmp - 2000) * (tmp - 2000);
        off2 = fsh(5 * a, 1);
        sens2 = fsh(5 * a, 2);
        if (tmp < -1500) begin
          b = (tmp + 1500) * (tmp + 1500);
          off2 += 7 * b;
          sens2 += fsh(11 * b, 1);
        end
        tmp -= t2;
        off -= off2;
        sens -= sens2;
      end
      p = fsh(fsh(longint'(d1) * sens, 21) - off, 15);
      tmp = tmp < -4000 ? -4000 : (tmp > 8500 ? 8500 : tmp);
      p = p < 1000 ? 1000 : (p > 120000 ? 120000 : p);
      r.temperature = tmp[14:0];
      r.pressure = p[16:0];
      // stuck pressure detector
      if (prev_pres == r.pressure) begin
        if (change_cnt > 1) change_cnt--;
        if (stuck_cnt < STUCK_LIMIT) stuck_cnt++;
      end else begin
        if (stuck_cnt > 1) stuck_cnt--;
        prev_pres = r.pressure;
        if (change_cnt < RECOVER_LIMIT) change_cnt++;
      end
      if (stuck_cnt == STUCK_LIMIT) begin
        stuck_f = 1;
        err_f = 1;
      end else if (change_cnt == RECOVER_LIMIT) begin
        stuck_f = 0;
      end
      if (clean_cnt < CLEAN_LIMIT) clean_cnt++;
      fault_cnt = 0;
    end else begin
      clean_cnt = 0;
      if (fault_cnt < FAULT_LIMIT) fault_cnt++;
      conn_f = 0;
      err_f = 1;
    end
    if (clean_cnt == CLEAN_LIMIT && !stuck_f) begin
      conn_f = 1;
      err_f = 0;
    end
    r.sample_valid = !flt;
    r.data_error = stuck_f;
    r.sensor_connected = conn_f;
    r.sensor_error = err_f;
    r.reinit_request = (fault_cnt == FAULT_LIMIT);
    return r;
  endfunction

  // Calibration write; only called with the block idle
  task automatic write_cal(input logic [IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx < NUM_COEF) cal[idx] = val;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // tvalid stays up after a beat unless the next item idles first
  task automatic send_reading(input logic [23:0] d1, input logic [23:0] d2,
                              input bit fixed, input baro_out_t fixed_res);
    baro_out_t pred;
    int idle_n;
    idle_n = $urandom_range(0, 11);
    if (idle_n != 0) begin
      s_tvalid <= 1'b0;
      repeat (idle_n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {d2, d1};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = compensate(d1, d2);
    if (fixed && pred != fixed_res) report("directed row disagrees with predictor");
    expected_q.push_back(fixed ? fixed_res : pred);
  endtask

  task automatic load_set(input int which);
    logic [15:0] v [NUM_COEF];
    case (which)
      0: v = '{40127, 36924, 23317, 23282, 33464, 28312};
      1: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      2: v = '{1, 1, 1, 1, 1, 1};
      default: for (int i = 0; i < NUM_COEF; i++) v[i] = 16'($urandom_range(1, 65535));
    endcase
    for (int i = 0; i < NUM_COEF; i++) write_cal(i[IDX_W-1:0], v[i]);
  endtask

  // Output side: random stall per beat, compare with oldest expectation
  initial begin
    baro_out_t got, exp_r;
    int stall_n;
    @(negedge rst);
    forever begin
      stall_n = $urandom_range(0, 11);
      if (stall_n != 0) begin
        m_tready <= 1'b0;
        repeat (stall_n) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = m_tdata[36:0];
      if (expected_q.size() == 0) begin
        report("output beat with nothing expected");
      end else begin
        exp_r = expected_q.pop_front();
        if (got.temperature != exp_r.temperature)
          report($sformatf("temperature %0d exp %0d", got.temperature, exp_r.temperature));
        if (got.pressure != exp_r.pressure)
          report($sformatf("pressure %0d exp %0d", got.pressure, exp_r.pressure));
        if (got.sample_valid != exp_r.sample_valid) report("sample_valid");
        if (got.data_error != exp_r.data_error) report("data_error");
        if (got.sensor_connected != exp_r.sensor_connected) report("sensor_connected");
        if (got.sensor_error != exp_r.sensor_error) report("sensor_error");
        if (got.reinit_request != exp_r.reinit_request) report("reinit_request");
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    baro_out_t flt_r;
    logic [23:0] d1, d2, base;
    int sel;
    for (int i = 0; i < NUM_COEF; i++) cal[i] = '0;
    prev_pres = '0;
    {stuck_cnt, change_cnt, clean_cnt, fault_cnt} = '0;
    {stuck_f, conn_f, err_f} = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset every coefficient is zero: read fault
    flt_r = '0;
    flt_r.sensor_error = 1'b1;
    send_reading(24'd9085466, 24'd8569150, 1'b1, flt_r);
    wait_idle();

    // Out-of-range index must be ignored
    write_cal(3'd6, 16'h1234);
    write_cal(3'd7, 16'h5678);
    load_set(0);

    // Directed rows: extremes of the raw readings, cold, hot, runs
    rows.push_back('{24'd0, 24'd8569150, 1'b0, '0});
    rows.push_back('{24'hFFFFFF, 24'd8569150, 1'b0, '0});
    rows.push_back('{24'd9085466, 24'd0, 1'b0, '0});
    rows.push_back('{24'd9085466, 24'hFFFFFF, 1'b0, '0});
    rows.push_back('{24'd1, 24'd0, 1'b0, '0});
    rows.push_back('{24'd9085466, 24'd8569150, 1'b0, '0});
    rows.push_back('{24'd1, 24'd1, 1'b0, '0});
    rows.push_back('{24'hFFFFFE, 24'hFFFFFE, 1'b0, '0});
    rows.push_back('{24'd9085466, 24'd6000000, 1'b0, '0});
    rows.push_back('{24'd9085466, 24'd3000000, 1'b0, '0});
    rows.push_back('{24'd9085466, 24'd11000000, 1'b0, '0});
    for (int i = 0; i < 12; i++) rows.push_back('{24'd9085466, 24'd8569150, 1'b0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_reading(row.d1, row.d2, row.fixed, row.res);
    end
    wait_idle();

    // Random phases across coefficient settings
    for (int ph = 0; ph < 6; ph++) begin
      load_set(ph == 0 ? 0 : (ph == 1 ? 1 : (ph == 2 ? 2 : 3)));
      base = 24'($urandom_range(1, 24'hFFFFFE));
      for (int n = 0; n < RAND_ITEMS / 6; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          d1 = ($urandom_range(0, 1) != 0) ? 24'd0 : 24'hFFFFFF;
          d2 = 24'($urandom);
        end else if (sel < 10) begin
          d1 = 24'($urandom);
          d2 = ($urandom_range(0, 1) != 0) ? 24'd0 : 24'hFFFFFF;
        end else if (sel < 40) begin
          // repeated reading, drives the stuck detector
          d1 = base;
          d2 = 24'd8569150;
        end else if (sel < 70) begin
          d1 = 24'($urandom_range(7000000, 10000000));
          d2 = 24'($urandom_range(6000000, 10000000));
        end else begin
          d1 = 24'($urandom);
          d2 = 24'($urandom);
        end
        if (sel > 97) base = 24'($urandom_range(1, 24'hFFFFFE));
        send_reading(d1, d2, 1'b0, '0);
        // once per phase, hold off until every result is back
        if (n == 40) begin
          s_tvalid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
      end
      wait_idle();
    end

    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/bch_pkg.sv
rtl/core/bch_health.sv
rtl/core/baro_compensation_health_top.sv
sim/tb_baro_compensation_health_top.sv
